/* rtl/unordered_priority_queue_core_defines.svh */
// Assertion macros for the priority queue core RTL.
`ifndef UNORDERED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define UNORDERED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UPQ_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("upq assertion failed");
`define UPQ_ASSERT_HOLD(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("upq invariant broken");
`else
`define UPQ_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define UPQ_ASSERT_HOLD(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/upq_pkg.sv */
// Shared types and constants of the priority queue.
`timescale 1ns / 1ps
package upq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DELETED  = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_CUR,
        ST_CMP,
        ST_WR_I,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [15:0] prio;
        logic signed [31:0] data;
    } t_entry;

endpackage

/* rtl/upq_ram.sv */
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
module upq_ram
    import upq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/unordered_priority_queue_core.sv */
// Top level of the unordered-array priority queue with sort-on-delete.
//
//  Channel  | Dir | Handshake                         | Word
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | tdata {prio, data}, tuser op
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | tdata data, tuser status
//
// Insert, full and empty words are answered in the cycle after acceptance.
// A delete sorts the live entries, limited to the single comparator and the one read
// port of the entry store.
// Reset is synchronous and active low; it empties the queue and the output stage.
// A pending result does not block acceptance when the sink takes it in that cycle.
`timescale 1ns / 1ps
`include "unordered_priority_queue_core_defines.svh"
module unordered_priority_queue_core
    import upq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [47:0]        i_s_axis_tdata,   // data_in[31:0], priority_in[47:32]
    input  logic               i_s_axis_tuser,   // op[0]
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic signed [31:0] o_m_axis_tdata,   // data_out[31:0]
    output logic [1:0]         o_m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    t_entry          r_cur, n_cur;
    logic [31:0]     r_dout, n_dout;
    logic            r_ovalid, n_ovalid;
    t_status         r_ostatus, n_ostatus;
    logic [31:0]     r_odata, n_odata;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_rdata;

    logic            s_accept;
    logic            q_empty;
    logic            q_full;
    logic [IW-1:0]   i_next;
    logic [IW-1:0]   j_next;
    logic            last_head;

    assign q_empty   = (r_tail == '0);
    assign q_full    = (r_tail == IW'(DEPTH));
    assign i_next    = r_i + IW'(1);
    assign j_next    = r_j + IW'(1);
    assign last_head = (({1'b0, r_head} + IW'(1)) == r_tail);

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    upq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && (i_s_axis_tuser == OP_DELETE) && !q_empty) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: n_state = ST_CUR;
            ST_CUR:  n_state = (i_next < r_tail) ? ST_CMP : ST_WR_I;
            ST_CMP:  n_state = (j_next < r_tail) ? ST_CMP : ST_WR_I;
            ST_WR_I: n_state = ((r_i + IW'(2)) < r_tail) ? ST_RD_I : ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[AW-1:0];
        ram_wdata = r_cur;
        ram_raddr = r_i[AW-1:0];
        n_i       = r_i;
        n_j       = r_j;
        n_cur     = r_cur;
        n_dout    = r_dout;
        n_head    = r_head;
        n_tail    = r_tail;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_axis_tuser == OP_INSERT) begin
                        n_ovalid = 1'b1;
                        n_odata  = '0;
                        if (q_full) begin
                            n_ostatus = STAT_FULL;
                        end else begin
                            ram_we         = 1'b1;
                            ram_waddr      = r_tail[AW-1:0];
                            ram_wdata.data = i_s_axis_tdata[31:0];
                            ram_wdata.prio = i_s_axis_tdata[47:32];
                            n_tail         = r_tail + IW'(1);
                            n_ostatus      = STAT_INSERTED;
                        end
                    end else if (q_empty) begin
                        n_ovalid  = 1'b1;
                        n_odata   = '0;
                        n_ostatus = STAT_EMPTY;
                    end else begin
                        n_i = {1'b0, r_head};
                    end
                end
            end
            ST_RD_I: begin
                ram_raddr = r_i[AW-1:0];
            end
            ST_CUR: begin
                n_cur     = ram_rdata;
                n_j       = i_next;
                ram_raddr = i_next[AW-1:0];
            end
            ST_CMP: begin
                if (r_cur.prio < ram_rdata.prio) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[AW-1:0];
                    ram_wdata = r_cur;
                    n_cur     = ram_rdata;
                end
                n_j       = j_next;
                ram_raddr = j_next[AW-1:0];
            end
            ST_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[AW-1:0];
                ram_wdata = r_cur;
                if (r_i[AW-1:0] == r_head) begin
                    n_dout = r_cur.data;
                end
                n_i = i_next;
            end
            ST_DONE: begin
                n_ovalid  = 1'b1;
                n_ostatus = STAT_DELETED;
                n_odata   = r_dout;
                if (last_head) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = r_head + AW'(1);
                end
            end
            default: begin
                n_ovalid = r_ovalid && !i_m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_cur     <= n_cur;
        r_dout    <= n_dout;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ostatus;

    `UPQ_ASSERT_HOLD(a_head_below_tail, i_clk, i_rst_n, (r_tail == '0) ? (r_head == '0) : ({1'b0, r_head} < r_tail))
    `UPQ_ASSERT_IMPL(a_delete_starts_sort, i_clk, i_rst_n, (s_accept && (i_s_axis_tuser == OP_DELETE) && !q_empty) |=> (r_state == ST_RD_I))
    `UPQ_ASSERT_IMPL(a_scan_in_live_region, i_clk, i_rst_n, (r_state == ST_CMP) |-> (r_j < r_tail))

endmodule
